/* rtl/hlx_pkg.sv */
// hlx_pkg: shared types and constants for the href link extractor
// used by hlx_parser, hlx_out_fifo and html_href_link_extractor_unit
`timescale 1ns / 1ps
`default_nettype none

package hlx_pkg;

    localparam int LEN_W     = 16;
    localparam int PTR_W     = 2;
    localparam int OUT_DEPTH = 2 ** PTR_W;
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    localparam logic [LEN_W-1:0] LIMIT_RESET = 16'd4094;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       link_end;
        logic       run_last;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       slot0;
        res_t       slot1;
    } push_t;

endpackage

`default_nettype wire

/* rtl/hlx_parser.sv */
// hlx_parser: href matcher state and result generation for one byte
// depends on hlx_pkg
`timescale 1ns / 1ps
`default_nettype none

module hlx_parser
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    fire,
    input  wire logic [7:0]              c_in,
    input  wire logic                    eod_in,
    input  wire logic [hlx_pkg::LEN_W-1:0] max_len,
    output hlx_pkg::push_t               push
);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_H     = 3'd1;
    localparam logic [2:0] PH_HR    = 3'd2;
    localparam logic [2:0] PH_HRE   = 3'd3;
    localparam logic [2:0] PH_HREF  = 3'd4;
    localparam logic [2:0] PH_EQ    = 3'd5;
    localparam logic [2:0] PH_QUOTE = 3'd6;
    localparam logic [2:0] PH_BODY  = 3'd7;

    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;

    logic [2:0]                  phase_reg;
    logic [2:0]                  phase_next;
    logic [7:0]                  quote_reg;
    logic [7:0]                  quote_next;
    logic [hlx_pkg::LEN_W-1:0]   count_reg;
    logic [hlx_pkg::LEN_W-1:0]   count_next;

    logic [2:0]                  st_phase;
    logic [7:0]                  st_quote;
    logic [hlx_pkg::LEN_W-1:0]   st_count;
    logic [hlx_pkg::LEN_W-1:0]   body_cnt;
    logic                        is_ws;
    logic [7:0]                  lc;
    logic                        body;
    logic                        emit_a;
    logic                        emit_b;
    logic [7:0]                  a_byte;
    logic                        a_end;
    hlx_pkg::res_t               res_a;
    hlx_pkg::res_t               res_b;

    always_comb
    begin
        is_ws = (c_in == CH_SP) || (c_in >= 8'h09 && c_in <= 8'h0d);
        lc    = (c_in >= 8'h41 && c_in <= 8'h5a) ? (c_in | 8'h20) : c_in;

        st_phase = phase_reg;
        st_quote = quote_reg;
        st_count = count_reg;
        body     = 1'b0;
        body_cnt = count_reg;

        unique case (phase_reg)
            PH_START:
            begin
                if (lc == CH_H)
                    st_phase = PH_H;
            end
            PH_H:
                st_phase = (lc == CH_R) ? PH_HR : PH_START;
            PH_HR:
                st_phase = (lc == CH_E) ? PH_HRE : PH_START;
            PH_HRE:
                st_phase = (lc == CH_F) ? PH_HREF : PH_START;
            PH_HREF:
            begin
                if (!is_ws)
                    st_phase = (c_in == CH_EQ) ? PH_EQ : PH_START;
            end
            PH_EQ:
            begin
                if (!is_ws)
                begin
                    if (c_in == CH_DQ || c_in == CH_SQ)
                    begin
                        st_quote = c_in;
                        st_phase = PH_QUOTE;
                    end
                    else
                    begin
                        st_phase = PH_START;
                    end
                end
            end
            PH_QUOTE:
            begin
                if (!is_ws)
                begin
                    if (c_in == quote_reg)
                    begin
                        st_phase = PH_START;
                    end
                    else
                    begin
                        body     = 1'b1;
                        body_cnt = '0;
                    end
                end
            end
            default:
                body = 1'b1;
        endcase

        emit_a = 1'b0;
        a_byte = CH_NL;
        a_end  = 1'b1;
        if (body)
        begin
            if (c_in == quote_reg || body_cnt >= max_len)
            begin
                // link closed by its quote or by the length limit
                emit_a   = (body_cnt != '0);
                st_count = '0;
                st_phase = PH_START;
            end
            else
            begin
                emit_a   = 1'b1;
                a_byte   = is_ws ? CH_SP : c_in;
                a_end    = 1'b0;
                st_count = body_cnt + hlx_pkg::LEN_W'(1);
                st_phase = PH_BODY;
            end
        end

        // end of document flushes an open link
        emit_b = eod_in && (st_phase == PH_BODY) && (st_count != '0);

        if (eod_in)
        begin
            phase_next = PH_START;
            quote_next = '0;
            count_next = '0;
        end
        else
        begin
            phase_next = st_phase;
            quote_next = st_quote;
            count_next = st_count;
        end

        res_a.out_byte = a_byte;
        res_a.link_end = a_end;
        res_a.run_last = !emit_b;
        res_b.out_byte = CH_NL;
        res_b.link_end = 1'b1;
        res_b.run_last = 1'b1;

        push.n     = fire ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
        push.slot0 = emit_a ? res_a : res_b;
        push.slot1 = res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            quote_reg <= '0;
            count_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            quote_reg <= quote_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/hlx_out_fifo.sv */
// hlx_out_fifo: small result queue taking up to two results per cycle
// depends on hlx_pkg
`timescale 1ns / 1ps
`default_nettype none

module hlx_out_fifo
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire hlx_pkg::push_t push,
    input  wire logic    pop,
    output hlx_pkg::res_t  head,
    output logic         not_empty,
    output logic         room
);

    hlx_pkg::res_t                 mem [hlx_pkg::OUT_DEPTH];
    logic [hlx_pkg::PTR_W-1:0]     wr_reg;
    logic [hlx_pkg::PTR_W-1:0]     wr_next;
    logic [hlx_pkg::PTR_W-1:0]     rd_reg;
    logic [hlx_pkg::PTR_W-1:0]     rd_next;
    logic [hlx_pkg::CNT_W-1:0]     count_reg;
    logic [hlx_pkg::CNT_W-1:0]     count_next;
    logic [hlx_pkg::PTR_W-1:0]     wr_plus1;

    assign wr_plus1  = wr_reg + hlx_pkg::PTR_W'(1);
    assign head      = mem[rd_reg];
    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= hlx_pkg::CNT_W'(hlx_pkg::OUT_DEPTH - 2));

    always_comb
    begin
        wr_next    = wr_reg + hlx_pkg::PTR_W'(push.n);
        rd_next    = rd_reg + hlx_pkg::PTR_W'(pop);
        count_next = count_reg + hlx_pkg::CNT_W'(push.n) - hlx_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_reg] <= push.slot0;
        if (push.n[1])
            mem[wr_plus1] <= push.slot1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/html_href_link_extractor_unit.sv */
// html_href_link_extractor_unit: top level, input register, limit register
// depends on hlx_pkg, hlx_parser, hlx_out_fifo
//
// channel   signals                                   direction
// in        in_valid, in_stall, in_byte, end_of_doc  byte stream in
// out       out_valid, out_stall, out_byte,          link bytes out
//           link_end, run_last
// cfg       cfg_valid, cfg_ready, max_link_len        limit register write
//
// one input byte per cycle while in_stall is low; an accepted byte waits in the
// input register until the queue has room, then its results enter the queue and
// are visible on out; a two-result byte still goes at that rate; in_stall rises
// while a byte waits and over two results are queued; out drains one per cycle
// when out_stall is low; reset clears parser state and queue, sets limit to 4094
`timescale 1ns / 1ps
`default_nettype none

module html_href_link_extractor_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_doc,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             link_end,
    output logic             run_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] max_link_len
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [7:0]                    byte_reg;
    logic                          eod_reg;
    logic [hlx_pkg::LEN_W-1:0]     max_len_reg;
    logic                          load;
    logic                          fire;
    logic                          room;
    logic                          pop;
    hlx_pkg::push_t                push;
    hlx_pkg::res_t                 head;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && room;
    assign in_stall  = in_valid_reg && !room;
    assign load      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    assign out_byte  = head.out_byte;
    assign link_end  = head.link_end;
    assign run_last  = head.run_last;

    always_comb
    begin
        if (load)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            max_len_reg  <= hlx_pkg::LIMIT_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready)
                max_len_reg <= max_link_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_byte;
            eod_reg  <= end_of_doc;
        end
    end

    hlx_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .c_in    (byte_reg),
        .eod_in  (eod_reg),
        .max_len (max_len_reg),
        .push    (push)
    );

    hlx_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (out_valid),
        .room      (room)
    );

endmodule

`default_nettype wire
